### design/prime_test_counter_defines.svh
// ----------------------------------------------------------------------------
// prime_test_counter_defines.svh
// Assertion macros shared by the prime test counter.
// ----------------------------------------------------------------------------
`ifndef PRIME_TEST_COUNTER_DEFINES_SVH
`define PRIME_TEST_COUNTER_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define PTC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define PTC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/ptc_pkg.sv
// ----------------------------------------------------------------------------
// ptc_pkg
// Beat types and fixed constants of the prime test counter.
// ----------------------------------------------------------------------------
package ptc_pkg;

    localparam int unsigned CAND_W  = 32;
    localparam int unsigned COUNT_W = 32;

    typedef struct packed {
        logic [CAND_W-1:0] candidate;
        logic              restart_totals;
    } t_in_beat;

    typedef struct packed {
        logic               is_prime;
        logic [COUNT_W-1:0] prime_count;
        logic [CAND_W-1:0]  largest_prime;
    } t_out_beat;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // Candidates up to this value are decided by lookup.
    localparam int unsigned SMALL_LIMIT = 10;
    // Bit i set when i is prime, i <= SMALL_LIMIT (2, 3, 5, 7).
    localparam logic [15:0] SMALL_PRIME_MASK = 16'h00AC;

    localparam int unsigned THIRD_DIVISOR   = 3;
    localparam int unsigned FIRST_DIVISOR   = 5;
    localparam int unsigned PAIR_OFFSET     = 2;
    localparam int unsigned DIVISOR_STEP    = 6;
    // (d + 6)^2 = d^2 + 12*d + 36
    localparam int unsigned SQ_STEP_BIAS    = 36;

endpackage

### design/ptc_rem_unit.sv
// ----------------------------------------------------------------------------
// ptc_rem_unit
// Bit-serial restoring remainder: one dividend bit per cycle.
// ----------------------------------------------------------------------------
module ptc_rem_unit #(
    parameter int unsigned NW = 32,
    parameter int unsigned DW = 19
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_dividend,
    input  logic [DW-1:0] i_divisor,
    output logic          o_done,
    output logic          o_rem_zero
);

    localparam int unsigned CW = $clog2(NW);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [NW-1:0] r_num;
    logic [DW-1:0] r_div;
    logic [DW-1:0] r_rem;

    logic [DW:0]   n_trial;
    logic [DW-1:0] n_rem;

    always_comb begin
        n_trial = {r_rem, r_num[NW-1]};
        if (n_trial >= {1'b0, r_div}) begin
            n_rem = DW'(n_trial - {1'b0, r_div});
        end else begin
            n_rem = DW'(n_trial);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(NW - 1);
                r_num  <= i_dividend;
                r_div  <= i_divisor;
                r_rem  <= '0;
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_num <= {r_num[NW-2:0], 1'b0};
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_rem_zero = (r_rem == '0);

endmodule

### design/prime_test_counter.sv
// ----------------------------------------------------------------------------
// prime_test_counter
// Trial-division primality test (6k-1 / 6k+1) with running prime totals.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_data) carries one candidate
//   per beat plus a restart flag that clears the totals before that candidate
//   is counted. Output channel (o_out_valid / i_out_ready / o_out_data) gives
//   one beat per candidate: prime flag, prime count, largest prime.
//   Only the low NUMBER_WIDTH bits of the candidate are tested (32 at most).
// Operation:
//   Candidates up to 10 and even ones are decided without the remainder
//   unit. Other candidates are divided by 3, then by each divisor pair d,
//   d+2 (d = 5, 11, 17, ...) until d^2 exceeds the candidate; a 32-bit
//   prime tries up to ~11k such pairs.
//   A composite stops at its first zero remainder. The remainder unit, one
//   quotient bit per cycle while busy, paces the search.
//   o_in_ready is high only while no item is in work.
// Reset (synchronous, active low): totals cleared, no item in work, output
//   beat dropped.
// Stall: a finished result sits in the output register; the next item may be
//   accepted and worked on, but its result waits until the register frees.
// ----------------------------------------------------------------------------
`include "prime_test_counter_defines.svh"

module prime_test_counter #(
    parameter int unsigned NUMBER_WIDTH = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  ptc_pkg::t_in_beat i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output ptc_pkg::t_out_beat o_out_data
);

    // Tested width: candidate port is 32 bits.
    localparam int unsigned NW = (NUMBER_WIDTH < ptc_pkg::CAND_W) ?
                                 NUMBER_WIDTH : ptc_pkg::CAND_W;
    // Divisor width: d stays below sqrt(2^NW) + 6 with margin.
    localparam int unsigned DW = (NW + 1) / 2 + 2;
    localparam int unsigned SW = 2 * DW;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLASSIFY,
        ST_WAIT3,
        ST_BOUND,
        ST_WAITA,
        ST_WAITB,
        ST_FINISH
    } t_state;

    t_state                       r_state;
    logic [NW-1:0]                r_n;
    logic                         r_restart;
    logic [DW-1:0]                r_d;
    logic [SW-1:0]                r_sq;
    logic                         r_prime;
    logic [ptc_pkg::COUNT_W-1:0]  r_count;
    logic [NW-1:0]                r_largest;
    logic                         r_out_valid;
    ptc_pkg::t_out_beat           r_out;

    logic                         in_beat;
    logic                         is_small;
    logic                         past_bound;
    logic                         rem_start;
    logic [DW-1:0]                rem_divisor;
    logic                         rem_done;
    logic                         rem_zero;
    logic [ptc_pkg::COUNT_W-1:0]  n_count;
    logic [NW-1:0]                n_largest;
    logic [ptc_pkg::COUNT_W-1:0]  base_count;
    logic [NW-1:0]                base_largest;

    assign in_beat    = i_in_valid && o_in_ready;
    assign is_small   = (r_n <= NW'(ptc_pkg::SMALL_LIMIT));
    assign past_bound = (r_sq > SW'(r_n));

    // Divisor select for the shared remainder unit: 3, then d, then d+2.
    always_comb begin
        rem_start   = 1'b0;
        rem_divisor = r_d;
        case (r_state)
            ST_CLASSIFY: begin
                rem_start   = !is_small && r_n[0];
                rem_divisor = DW'(ptc_pkg::THIRD_DIVISOR);
            end
            ST_BOUND: begin
                rem_start   = !past_bound;
                rem_divisor = r_d;
            end
            ST_WAITA: begin
                rem_start   = rem_done && !rem_zero;
                rem_divisor = r_d + DW'(ptc_pkg::PAIR_OFFSET);
            end
            default: begin
                rem_start   = 1'b0;
                rem_divisor = r_d;
            end
        endcase
    end

    ptc_rem_unit #(
        .NW(NW),
        .DW(DW)
    ) u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (rem_start),
        .i_dividend (r_n),
        .i_divisor  (rem_divisor),
        .o_done     (rem_done),
        .o_rem_zero (rem_zero)
    );

    // Totals after this item: restart clears first, count saturates.
    always_comb begin
        base_count   = r_restart ? '0 : r_count;
        base_largest = r_restart ? '0 : r_largest;
        n_count      = base_count;
        n_largest    = base_largest;
        if (r_prime) begin
            if (base_count != ptc_pkg::COUNT_MAX) begin
                n_count = base_count + 1'b1;
            end
            if (r_n > base_largest) begin
                n_largest = r_n;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_largest   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // FINISH owns the output register while it loads a new beat
            if (r_out_valid && i_out_ready && r_state != ST_FINISH) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (in_beat) begin
                        r_n       <= NW'(i_in_data.candidate);
                        r_restart <= i_in_data.restart_totals;
                        r_state   <= ST_CLASSIFY;
                    end
                end
                ST_CLASSIFY: begin
                    r_d  <= DW'(ptc_pkg::FIRST_DIVISOR);
                    r_sq <= SW'(ptc_pkg::FIRST_DIVISOR * ptc_pkg::FIRST_DIVISOR);
                    if (is_small) begin
                        r_prime <= ptc_pkg::SMALL_PRIME_MASK[r_n[3:0]];
                        r_state <= ST_FINISH;
                    end else if (!r_n[0]) begin
                        r_prime <= 1'b0;
                        r_state <= ST_FINISH;
                    end else begin
                        r_state <= ST_WAIT3;
                    end
                end
                ST_WAIT3: begin
                    if (rem_done) begin
                        if (rem_zero) begin
                            r_prime <= 1'b0;
                            r_state <= ST_FINISH;
                        end else begin
                            r_state <= ST_BOUND;
                        end
                    end
                end
                ST_BOUND: begin
                    if (past_bound) begin
                        r_prime <= 1'b1;
                        r_state <= ST_FINISH;
                    end else begin
                        r_state <= ST_WAITA;
                    end
                end
                ST_WAITA: begin
                    if (rem_done) begin
                        if (rem_zero) begin
                            r_prime <= 1'b0;
                            r_state <= ST_FINISH;
                        end else begin
                            r_state <= ST_WAITB;
                        end
                    end
                end
                ST_WAITB: begin
                    if (rem_done) begin
                        if (rem_zero) begin
                            r_prime <= 1'b0;
                            r_state <= ST_FINISH;
                        end else begin
                            // next pair: d += 6, d^2 += 12d + 36
                            r_d     <= r_d + DW'(ptc_pkg::DIVISOR_STEP);
                            r_sq    <= r_sq + (SW'(r_d) << 3) + (SW'(r_d) << 2)
                                       + SW'(ptc_pkg::SQ_STEP_BIAS);
                            r_state <= ST_BOUND;
                        end
                    end
                end
                ST_FINISH: begin
                    // wait for the output register to free up
                    if (!r_out_valid || i_out_ready) begin
                        r_count                 <= n_count;
                        r_largest               <= n_largest;
                        r_out.is_prime          <= r_prime;
                        r_out.prime_count       <= n_count;
                        r_out.largest_prime     <= ptc_pkg::CAND_W'(n_largest);
                        r_out_valid             <= 1'b1;
                        r_state                 <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    `PTC_ASSERT_NOW(a_prime_counted, o_out_valid && o_out_data.is_prime, o_out_data.prime_count != '0 && o_out_data.largest_prime != '0, "prime beat with empty totals")
    `PTC_ASSERT_NEXT(a_busy_after_accept, i_in_valid && o_in_ready, !o_in_ready, "ready held after accepting a beat")
    `PTC_ASSERT_NOW(a_rem_start_busy, rem_start, r_state == ST_CLASSIFY || r_state == ST_BOUND || r_state == ST_WAITA, "remainder started outside the test loop")

endmodule
